### rtl/gbn_pkg.sv
// Shared types, codes and sequence-number helpers for the go-back-N engine.
// Depends on nothing; every other file in rtl/ uses it by scoped names.
`timescale 1ns / 1ps

package gbn_pkg;

  // Sequence numbers run modulo SEQ_MAX + 1, which is 2**SEQ_W, so plain
  // SEQ_W-bit wrap-around arithmetic is the modulo.
  localparam int SEQ_MAX = 7;
  localparam int SEQ_W   = 3;
  localparam int DATA_W  = 32;

  localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_MAX);

  // Depth of the command queue between front and back (a power of two).
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Input operations.
  localparam logic [1:0] OP_NET_READY = 2'd0;
  localparam logic [1:0] OP_ARRIVAL   = 2'd1;
  localparam logic [1:0] OP_CKSUM_ERR = 2'd2;
  localparam logic [1:0] OP_TIMEOUT   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_FRAME   = 2'd0;
  localparam logic [1:0] KIND_DELIVER = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // Status codes.
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_DROPPED = 1'b1;

  // Commands handed from the front end to the back end.
  localparam logic [1:0] CMD_SEND   = 2'd0;
  localparam logic [1:0] CMD_ARRIVE = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;
  localparam logic [1:0] CMD_REPLAY = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [DATA_W-1:0] payload;
    logic [SEQ_W-1:0]  frame_seq;
    logic [SEQ_W-1:0]  frame_ack;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [SEQ_W-1:0]  out_ack;
    logic [DATA_W-1:0] out_payload;
    logic              status_code;
    logic [SEQ_W-1:0]  outstanding;
    logic              can_accept;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] payload;
    logic [SEQ_W-1:0]  seq;         // frame to send, or first frame to replay
    logic [SEQ_W-1:0]  ack;         // piggybacked ack for transmitted frames
    logic [SEQ_W-1:0]  nframes;     // frames to replay
    logic              deliver;     // arrival was in order
    logic              status;
    logic [SEQ_W-1:0]  outstanding; // buffered count after the item
    logic              can_accept;
  } cmd_t;

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] v);
    seq_inc = v + SEQ_W'(1);
  endfunction

  // True when a <= b < c, circularly.
  function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                     input logic [SEQ_W-1:0] b,
                                     input logic [SEQ_W-1:0] c);
    in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                ((b < c) && (c < a));
  endfunction

endpackage

### rtl/gbn_front.sv
// Front end: accepts input words, keeps the window pointers and turns each
// word into one command for the back end. Depends on gbn_pkg.
`timescale 1ns / 1ps

module gbn_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  gbn_pkg::in_word_t in_word,
  input  logic             q_full,
  output logic             q_push,
  output gbn_pkg::cmd_t    q_cmd
);

  logic [gbn_pkg::SEQ_W-1:0] send_next_r, send_next_nxt;
  logic [gbn_pkg::SEQ_W-1:0] ack_oldest_r, ack_oldest_nxt;
  logic [gbn_pkg::SEQ_W-1:0] recv_exp_r, recv_exp_nxt;
  logic [gbn_pkg::SEQ_W-1:0] count_r, count_nxt;
  logic [gbn_pkg::SEQ_W-1:0] ack_dist;

  assign q_push   = in_valid && !q_full;
  assign ack_dist = in_word.frame_ack - ack_oldest_r;

  always_comb begin
    send_next_nxt  = send_next_r;
    ack_oldest_nxt = ack_oldest_r;
    recv_exp_nxt   = recv_exp_r;
    count_nxt      = count_r;

    q_cmd          = '0;
    q_cmd.payload  = in_word.payload;
    q_cmd.ack      = recv_exp_r - gbn_pkg::SEQ_W'(1);
    q_cmd.status   = gbn_pkg::STAT_OK;

    case (in_word.operation)
      gbn_pkg::OP_NET_READY: begin
        if (count_r >= gbn_pkg::SEQ_LAST) begin
          q_cmd.kind   = gbn_pkg::CMD_STATUS;
          q_cmd.status = gbn_pkg::STAT_DROPPED;
        end else begin
          q_cmd.kind    = gbn_pkg::CMD_SEND;
          q_cmd.seq     = send_next_r;
          count_nxt     = count_r + gbn_pkg::SEQ_W'(1);
          send_next_nxt = gbn_pkg::seq_inc(send_next_r);
        end
      end
      gbn_pkg::OP_ARRIVAL: begin
        q_cmd.kind    = gbn_pkg::CMD_ARRIVE;
        q_cmd.deliver = (in_word.frame_seq == recv_exp_r);
        if (q_cmd.deliver) begin
          recv_exp_nxt = gbn_pkg::seq_inc(recv_exp_r);
        end
        // The outstanding frames always span ack_oldest .. send_next-1, so
        // an ack inside that span releases everything up to and including it.
        if (gbn_pkg::in_window(ack_oldest_r, in_word.frame_ack, send_next_r)) begin
          count_nxt      = count_r - gbn_pkg::seq_inc(ack_dist);
          ack_oldest_nxt = gbn_pkg::seq_inc(in_word.frame_ack);
        end
      end
      gbn_pkg::OP_TIMEOUT: begin
        q_cmd.kind    = gbn_pkg::CMD_REPLAY;
        q_cmd.seq     = ack_oldest_r;
        q_cmd.nframes = count_r;
      end
      default: begin
        q_cmd.kind = gbn_pkg::CMD_STATUS;
      end
    endcase

    q_cmd.outstanding = count_nxt;
    q_cmd.can_accept  = (count_nxt < gbn_pkg::SEQ_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_next_r  <= '0;
      ack_oldest_r <= '0;
      recv_exp_r   <= '0;
      count_r      <= '0;
    end else if (q_push) begin
      send_next_r  <= send_next_nxt;
      ack_oldest_r <= ack_oldest_nxt;
      recv_exp_r   <= recv_exp_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

### rtl/gbn_cmd_q.sv
// Short command queue between the front and back ends.
// Depends on gbn_pkg for the command type and depth.
`timescale 1ns / 1ps

module gbn_cmd_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gbn_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output gbn_pkg::cmd_t head
);

  gbn_pkg::cmd_t                 slots_r [gbn_pkg::CMDQ_DEPTH];
  logic [gbn_pkg::CMDQ_AW-1:0]   wr_ptr_r;
  logic [gbn_pkg::CMDQ_AW-1:0]   rd_ptr_r;
  logic [gbn_pkg::CMDQ_CW-1:0]   fill_r;

  assign full  = (fill_r == gbn_pkg::CMDQ_CW'(gbn_pkg::CMDQ_DEPTH));
  assign empty = (fill_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers wrap naturally because the depth is a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + gbn_pkg::CMDQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + gbn_pkg::CMDQ_AW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + gbn_pkg::CMDQ_CW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - gbn_pkg::CMDQ_CW'(1);
      end
    end
  end

endmodule

### rtl/gbn_back.sv
// Back end: executes queued commands, owns the window buffer and drives the
// result register one word per cycle while taken. Depends on gbn_pkg.
`timescale 1ns / 1ps

module gbn_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  gbn_pkg::cmd_t     q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_take,
  output gbn_pkg::out_word_t out_word
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REPLAY = 2'd1;
  localparam logic [1:0] ST_STATUS = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [gbn_pkg::SEQ_W-1:0]   seq_r, seq_nxt;
  logic [gbn_pkg::SEQ_W-1:0]   left_r, left_nxt;
  logic [gbn_pkg::DATA_W-1:0]  mem [gbn_pkg::SEQ_MAX+1];
  logic [gbn_pkg::DATA_W-1:0]  rd_data_r;
  logic [gbn_pkg::SEQ_W-1:0]   rd_addr;
  logic                        mem_we;
  logic                        slot_free;
  logic                        emit;
  gbn_pkg::out_word_t          word;
  gbn_pkg::out_word_t          out_r;
  logic                        out_valid_r;

  assign slot_free = !out_valid_r || out_take;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    state_nxt = state_r;
    seq_nxt   = seq_r;
    left_nxt  = left_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = seq_r;

    word             = '0;
    word.outstanding = q_head.outstanding;
    word.can_accept  = q_head.can_accept;

    case (state_r)
      ST_IDLE: begin
        rd_addr = q_head.seq;
        if (!q_empty && slot_free) begin
          case (q_head.kind)
            gbn_pkg::CMD_SEND: begin
              emit             = 1'b1;
              mem_we           = 1'b1;
              word.result_kind = gbn_pkg::KIND_FRAME;
              word.out_seq     = q_head.seq;
              word.out_ack     = q_head.ack;
              word.out_payload = q_head.payload;
              state_nxt        = ST_STATUS;
            end
            gbn_pkg::CMD_ARRIVE: begin
              emit = 1'b1;
              if (q_head.deliver) begin
                word.result_kind = gbn_pkg::KIND_DELIVER;
                word.out_payload = q_head.payload;
                state_nxt        = ST_STATUS;
              end else begin
                word.result_kind = gbn_pkg::KIND_STATUS;
                word.status_code = q_head.status;
                word.last        = 1'b1;
                q_pop            = 1'b1;
              end
            end
            gbn_pkg::CMD_REPLAY: begin
              if (q_head.nframes == '0) begin
                emit             = 1'b1;
                word.result_kind = gbn_pkg::KIND_STATUS;
                word.status_code = q_head.status;
                word.last        = 1'b1;
                q_pop            = 1'b1;
              end else begin
                // The read of the first frame is issued this cycle.
                seq_nxt   = q_head.seq;
                left_nxt  = q_head.nframes;
                state_nxt = ST_REPLAY;
              end
            end
            default: begin
              emit             = 1'b1;
              word.result_kind = gbn_pkg::KIND_STATUS;
              word.status_code = q_head.status;
              word.last        = 1'b1;
              q_pop            = 1'b1;
            end
          endcase
        end
      end
      ST_REPLAY: begin
        if (slot_free) begin
          emit             = 1'b1;
          word.result_kind = gbn_pkg::KIND_FRAME;
          word.out_seq     = seq_r;
          word.out_ack     = q_head.ack;
          word.out_payload = rd_data_r;
          seq_nxt          = gbn_pkg::seq_inc(seq_r);
          left_nxt         = left_r - gbn_pkg::SEQ_W'(1);
          rd_addr          = gbn_pkg::seq_inc(seq_r);
          if (left_r == gbn_pkg::SEQ_W'(1)) begin
            state_nxt = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          emit             = 1'b1;
          word.result_kind = gbn_pkg::KIND_STATUS;
          word.status_code = q_head.status;
          word.last        = 1'b1;
          q_pop            = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Window buffer: sends write it, unstalled replay reads one frame a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_head.seq] <= q_head.payload;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= word;
    end
    seq_r  <= seq_nxt;
    left_r <= left_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### rtl/go_back_n_sliding_window.sv
// Top level of the go-back-N sliding-window engine: front end, command
// queue and back end. Depends on gbn_pkg, gbn_front, gbn_cmd_q and gbn_back.
`timescale 1ns / 1ps

// This block is a go-back-N sender and in-order receiver with a window of
// eight sequence numbers (at most seven frames outstanding). Input words are
// pushed like into a queue and result words are popped like from a queue;
// every input word ends with exactly one status word marked last, preceded
// by its transmitted frames or its delivered packet. The front end takes one
// input word per cycle as long as its two-entry command queue has room; it
// updates the window pointers at once, so every result word of an item
// already carries the outstanding count after that item. The back end sends
// one result word per cycle from a single output register while the words
// are popped: a network-ready word yields a frame and a status word, an
// in-order arrival a delivery and a status word, an out-of-order arrival,
// a checksum error or a dropped packet only a status word, a timeout with
// nothing outstanding only a status word, and a timeout with N frames
// outstanding a first window-buffer read, then one frame per cycle, then the
// status. The sustained rate is set by that output register and the
// registered read of the window buffer. Buffer entries need no clearing after
// reset, since only buffered frames are ever read back.
module go_back_n_sliding_window (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  gbn_pkg::in_word_t  in_word,
  output logic               empty,
  input  logic               pop,
  output gbn_pkg::out_word_t out_word
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  gbn_pkg::cmd_t q_cmd;
  gbn_pkg::cmd_t q_head;
  logic          out_valid;

  // The input side stalls only when the command queue is full.
  assign full  = q_full;
  assign empty = !out_valid;

  gbn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (push),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  gbn_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  gbn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_take  (pop),
    .out_word  (out_word)
  );

`ifndef ASSERT_OFF
  // Exactly the status word closes an item.
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_word.last == (out_word.result_kind == gbn_pkg::KIND_STATUS)))
    else $error("last flag and status kind disagree");

  // The room flag follows the outstanding count.
  a_room_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_word.can_accept == (out_word.outstanding < gbn_pkg::SEQ_LAST)))
    else $error("can_accept inconsistent with outstanding");

  // The back end retires a command only when one is queued.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command queue popped while empty");

  // A retired command always leaves a status word in the output register.
  a_pop_emits_status: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (!empty && out_word.last))
    else $error("command retired without a status word");
`endif

endmodule
